>>> rtl/core/flbr_pkg.sv
// Shared constants, codes and types of the fused linear, bias and ReLU block.
`timescale 1ns / 1ps

package flbr_pkg;

   // Store geometry
   localparam int MAX_INNER   = 256;
   localparam int MAX_COLUMNS = 64;
   localparam int DATA_WIDTH  = 16;

   localparam int INNER_AW  = $clog2(MAX_INNER);
   localparam int COL_AW    = $clog2(MAX_COLUMNS);
   localparam int WEIGHT_AW = INNER_AW + COL_AW;

   // Arithmetic widths: Q8.8 data, Q16.16 products and results
   localparam int FRAC_BITS    = 8;
   localparam int PROD_WIDTH   = 2 * DATA_WIDTH;
   localparam int ACC_WIDTH    = 40;
   localparam int RESULT_WIDTH = 32;

   // Field and register widths
   localparam int OPCODE_W    = 2;
   localparam int INNER_IDX_W = 8;
   localparam int COL_IDX_W   = 6;
   localparam int VALUE_W     = 16;
   localparam int ROW_WIDTH   = 16;
   localparam int ROW_TOTAL_W = 16;
   localparam int INNER_LEN_W = 9;
   localparam int COL_TOTAL_W = 7;

   localparam int REQ_FIELDS_W = INNER_IDX_W + COL_IDX_W + VALUE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = RESULT_WIDTH + COL_IDX_W + ROW_WIDTH;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_TOTAL    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_TOTAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELU_ON      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_ON      = 3'd4;

   // Input word kinds
   localparam logic [OPCODE_W-1:0] OP_WEIGHT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_BIAS   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_ACT    = 2'd2;

   // Tags that travel with a finished accumulator into the output stage
   typedef struct packed {
      logic [COL_AW-1:0]    col;
      logic                 row_last;
      logic                 batch_last;
      logic [ROW_WIDTH-1:0] row;
   } post_ctrl_type;

endpackage

>>> rtl/core/flbr_post.sv
// Output stage: bias add, ReLU clamp, 32-bit saturation and the result register.
`timescale 1ns / 1ps

module flbr_post (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  flbr_pkg::post_ctrl_type         in_ctrl,
   input  logic [flbr_pkg::ACC_WIDTH-1:0]  in_sum,
   input  logic [flbr_pkg::DATA_WIDTH-1:0] in_bias,
   input  logic                            relu_on,
   input  logic                            bias_on,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // result_value, result_column, result_row, zero pad
   output logic [flbr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,   // row_last
   output logic                            rsp_tuser    // batch_last
);
   import flbr_pkg::*;

   localparam int EXT_W = ACC_WIDTH + 1;
   localparam int TOP_W = EXT_W - RESULT_WIDTH + 1;

   logic signed [EXT_W-1:0]  v_sum;
   logic signed [EXT_W-1:0]  v_bias;
   logic signed [EXT_W-1:0]  v_tot;
   logic signed [EXT_W-1:0]  v_relu;
   logic [TOP_W-1:0]         v_top;
   logic [RESULT_WIDTH-1:0]  value_in;

   logic                     rsp_vld_ff;
   logic [RESULT_WIDTH-1:0]  rsp_val_ff;
   post_ctrl_type            rsp_ctrl_ff;

   // Bias is Q8.8, shifted up to Q16.16 before the add
   always_comb begin
      v_sum  = $signed({in_sum[ACC_WIDTH-1], in_sum});
      v_bias = bias_on
             ? $signed({{(EXT_W - DATA_WIDTH - FRAC_BITS){in_bias[DATA_WIDTH-1]}},
                        in_bias, {FRAC_BITS{1'b0}}})
             : '0;
      v_tot  = v_sum + v_bias;
      v_relu = (relu_on && v_tot[EXT_W-1]) ? '0 : v_tot;
   end

   // Saturate when the bits above the result sign do not all match it
   always_comb begin
      v_top = v_relu[EXT_W-1:RESULT_WIDTH-1];
      if ((v_top == '0) || (v_top == '1)) begin
         value_in = v_relu[RESULT_WIDTH-1:0];
      end else begin
         value_in = {v_relu[EXT_W-1], {(RESULT_WIDTH-1){~v_relu[EXT_W-1]}}};
      end
   end

   assign in_ready = !rsp_vld_ff || rsp_tready;

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_vld_ff <= in_valid;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_val_ff  <= value_in;
         rsp_ctrl_ff <= in_ctrl;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}},
                        rsp_ctrl_ff.row, rsp_ctrl_ff.col, rsp_val_ff};
   assign rsp_tlast  = rsp_ctrl_ff.row_last;
   assign rsp_tuser  = rsp_ctrl_ff.batch_last;

endmodule

>>> rtl/core/fused_linear_bias_relu.sv
// Top level: weight, bias and accumulator stores with a shared multiply-accumulate sweep.
`timescale 1ns / 1ps

// Usage.
// The req_ channel carries three kinds of word, told apart by req_tuser: a weight
// write (inner row, column, value), a bias write (column, value) and an activation
// element (value). Weights and biases go into on-chip RAMs. Each activation element
// starts a sweep over the active columns: one column per cycle, while the sweep is
// not frozen, reads its weight and accumulator, multiplies, adds and writes back.
// The next word waits until the sweep has left its issue, read and multiply stages.
// After the last inner element of a row the sweep sends each column's sum through
// bias add and ReLU, each when enabled, and saturation; rsp_ carries one word per
// column, in column order, one per cycle while rsp_ is not stalled. rsp_tlast marks
// the last column of a row, rsp_tuser the end of a batch. A stalled rsp_ freezes the
// sweep in place; req_ keeps taking words once the sweep has drained. The csr_
// channel is always ready and must be written only while idle; keeping to this is
// left to the user. Reset sets every register to its default, zeroes the row and
// inner positions and marks all accumulators empty; weight and bias RAMs are not
// cleared.

module fused_linear_bias_relu (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // inner_index, column_index, data_value, zero pad
   input  logic [flbr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [flbr_pkg::OPCODE_W-1:0]   req_tuser,   // opcode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // result_value, result_column, result_row, zero pad
   output logic [flbr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,   // row_last
   output logic                            rsp_tuser,   // batch_last
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [flbr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [flbr_pkg::CSR_DATA_W-1:0] csr_data
);
   import flbr_pkg::*;

   // Registers
   logic [ROW_TOTAL_W-1:0]  row_total_ff;
   logic [INNER_LEN_W-1:0]  inner_len_ff;
   logic [COL_TOTAL_W-1:0]  col_total_ff;
   logic                    relu_ff;
   logic                    bias_on_ff;

   // Input word fields
   logic [INNER_IDX_W-1:0]  req_inner;
   logic [COL_IDX_W-1:0]    req_col;
   logic [VALUE_W-1:0]      req_value;
   logic                    req_acc;
   logic                    act_acc;

   // Effective lengths and positions
   logic [ROW_TOTAL_W-1:0]  rows_eff;
   logic [INNER_LEN_W-1:0]  inner_eff;
   logic [INNER_LEN_W-1:0]  inner_max;
   logic [COL_TOTAL_W-1:0]  cols_eff;
   logic [INNER_AW-1:0]     k_sel;
   logic                    final_sel;
   logic                    bend_sel;
   logic [INNER_AW-1:0]     inner_pos_ff;
   logic [ROW_WIDTH-1:0]    row_pos_ff;

   // Current activation
   logic [DATA_WIDTH-1:0]   act_ff;
   logic [INNER_AW-1:0]     k_ff;
   logic                    final_ff;
   logic                    item_bend_ff;
   logic [ROW_WIDTH-1:0]    item_row_ff;
   logic [COL_TOTAL_W-1:0]  cols_ff;

   // Sweep issue
   logic                    issue_ff;
   logic [COL_AW-1:0]       col_ff;
   logic                    issue_last;
   logic                    adv;

   // Stores
   logic [DATA_WIDTH-1:0]   weight_mem [MAX_INNER*MAX_COLUMNS];
   logic [DATA_WIDTH-1:0]   bias_mem   [MAX_COLUMNS];
   logic [ACC_WIDTH-1:0]    acc_mem    [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0]  acc_vld_ff;

   // Read stage
   logic                    r_vld_ff;
   logic [COL_AW-1:0]       r_col_ff;
   logic                    r_last_ff;
   logic [DATA_WIDTH-1:0]   w_rd_ff;
   logic [DATA_WIDTH-1:0]   bias_rd_ff;
   logic [ACC_WIDTH-1:0]    acc_rd_ff;
   logic                    acc_vld_rd_ff;

   // Multiply stage
   logic                    m_vld_ff;
   logic [COL_AW-1:0]       m_col_ff;
   logic                    m_last_ff;
   logic signed [PROD_WIDTH-1:0] prod_in;
   logic [PROD_WIDTH-1:0]   prod_ff;
   logic [ACC_WIDTH-1:0]    m_acc_ff;
   logic [DATA_WIDTH-1:0]   m_bias_ff;

   // Add stage
   logic [ACC_WIDTH-1:0]    a_sum_in;
   logic                    acc_we;
   logic                    acc_clear;
   logic                    a_vld_ff;
   logic [ACC_WIDTH-1:0]    a_sum_ff;
   logic [DATA_WIDTH-1:0]   a_bias_ff;
   post_ctrl_type           a_ctrl_ff;
   logic                    post_ready;

   // Word unpacking
   assign req_inner = req_tdata[INNER_IDX_W-1:0];
   assign req_col   = req_tdata[INNER_IDX_W +: COL_IDX_W];
   assign req_value = req_tdata[INNER_IDX_W + COL_IDX_W +: VALUE_W];

   assign req_tready = !issue_ff && !r_vld_ff && !m_vld_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign act_acc    = req_acc && (req_tuser == OP_ACT);
   assign csr_ready  = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         row_total_ff <= ROW_TOTAL_W'(1);
         inner_len_ff <= INNER_LEN_W'(1);
         col_total_ff <= COL_TOTAL_W'(1);
         relu_ff      <= 1'b0;
         bias_on_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROW_TOTAL:    row_total_ff <= csr_data[ROW_TOTAL_W-1:0];
            CSR_INNER_LENGTH: inner_len_ff <= csr_data[INNER_LEN_W-1:0];
            CSR_COLUMN_TOTAL: col_total_ff <= csr_data[COL_TOTAL_W-1:0];
            CSR_RELU_ON:      relu_ff      <= csr_data[0];
            CSR_BIAS_ON:      bias_on_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Zero acts as one; oversized lengths are clipped to the store size
   always_comb begin
      rows_eff  = (row_total_ff == '0) ? ROW_TOTAL_W'(1) : row_total_ff;
      if (inner_len_ff == '0) begin
         inner_eff = INNER_LEN_W'(1);
      end else if (inner_len_ff > INNER_LEN_W'(MAX_INNER)) begin
         inner_eff = INNER_LEN_W'(MAX_INNER);
      end else begin
         inner_eff = inner_len_ff;
      end
      if (col_total_ff == '0) begin
         cols_eff = COL_TOTAL_W'(1);
      end else if (col_total_ff > COL_TOTAL_W'(MAX_COLUMNS)) begin
         cols_eff = COL_TOTAL_W'(MAX_COLUMNS);
      end else begin
         cols_eff = col_total_ff;
      end
      inner_max = inner_eff - 1'b1;
      // A position past a shrunken length counts as the last one
      k_sel     = ({1'b0, inner_pos_ff} >= inner_max) ? inner_max[INNER_AW-1:0]
                                                      : inner_pos_ff;
      final_sel = (({1'b0, k_sel} + 1'b1) >= inner_eff);
      bend_sel  = (({1'b0, row_pos_ff} + 1'b1) >= {1'b0, rows_eff});
   end

   // Inner and row positions
   always_ff @(posedge clock) begin
      if (reset) begin
         inner_pos_ff <= '0;
         row_pos_ff   <= '0;
      end else if (act_acc) begin
         if (final_sel) begin
            inner_pos_ff <= '0;
            row_pos_ff   <= bend_sel ? '0 : row_pos_ff + 1'b1;
         end else begin
            inner_pos_ff <= k_sel + 1'b1;
         end
      end
   end

   // Activation held for the whole sweep
   always_ff @(posedge clock) begin
      if (act_acc) begin
         act_ff       <= req_value[DATA_WIDTH-1:0];
         k_ff         <= k_sel;
         final_ff     <= final_sel;
         item_bend_ff <= bend_sel;
         item_row_ff  <= row_pos_ff;
         cols_ff      <= cols_eff;
      end
   end

   // The whole sweep freezes while a finished sum waits on the output stage
   assign adv        = !a_vld_ff || post_ready;
   assign issue_last = ({1'b0, col_ff} == (cols_ff - 1'b1));

   // Column issue counter and stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         col_ff   <= '0;
         r_vld_ff <= 1'b0;
         m_vld_ff <= 1'b0;
         a_vld_ff <= 1'b0;
      end else begin
         if (act_acc) begin
            issue_ff <= 1'b1;
            col_ff   <= '0;
         end else if (adv && issue_ff) begin
            if (issue_last) begin
               issue_ff <= 1'b0;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
         if (adv) begin
            r_vld_ff <= issue_ff;
            m_vld_ff <= r_vld_ff;
            a_vld_ff <= m_vld_ff && final_ff;
         end
      end
   end

   // Weight RAM
   always_ff @(posedge clock) begin
      if (req_acc && (req_tuser == OP_WEIGHT)) begin
         weight_mem[{req_inner[INNER_AW-1:0], req_col[COL_AW-1:0]}] <= req_value;
      end
      if (adv) begin
         w_rd_ff <= weight_mem[{k_ff, col_ff}];
      end
   end

   // Bias RAM
   always_ff @(posedge clock) begin
      if (req_acc && (req_tuser == OP_BIAS)) begin
         bias_mem[req_col[COL_AW-1:0]] <= req_value;
      end
      if (adv) begin
         bias_rd_ff <= bias_mem[col_ff];
      end
   end

   // Accumulator RAM; writes come back from the add stage
   assign acc_we    = adv && m_vld_ff && !final_ff;
   assign acc_clear = adv && m_vld_ff && final_ff && m_last_ff;

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[m_col_ff] <= a_sum_in;
      end
      if (adv) begin
         acc_rd_ff <= acc_mem[col_ff];
      end
   end

   // Accumulator valid bits: an empty entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= '0;
      end else if (acc_clear) begin
         acc_vld_ff <= '0;
      end else if (acc_we) begin
         acc_vld_ff[m_col_ff] <= 1'b1;
      end
   end

   // Read stage tags
   always_ff @(posedge clock) begin
      if (adv) begin
         r_col_ff      <= col_ff;
         r_last_ff     <= issue_last;
         acc_vld_rd_ff <= acc_vld_ff[col_ff];
      end
   end

   // Multiply stage
   assign prod_in = $signed(act_ff) * $signed(w_rd_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= prod_in;
         m_acc_ff  <= acc_vld_rd_ff ? acc_rd_ff : '0;
         m_bias_ff <= bias_rd_ff;
         m_col_ff  <= r_col_ff;
         m_last_ff <= r_last_ff;
      end
   end

   // Add stage: 40-bit wrapping accumulate
   assign a_sum_in = m_acc_ff + {{(ACC_WIDTH - PROD_WIDTH){prod_ff[PROD_WIDTH-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         a_sum_ff             <= a_sum_in;
         a_bias_ff            <= m_bias_ff;
         a_ctrl_ff.col        <= m_col_ff;
         a_ctrl_ff.row_last   <= m_last_ff;
         a_ctrl_ff.batch_last <= m_last_ff && item_bend_ff;
         a_ctrl_ff.row        <= item_row_ff;
      end
   end

   // Bias, ReLU, saturation and result register
   flbr_post u_post (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (a_vld_ff),
      .in_ready   (post_ready),
      .in_ctrl    (a_ctrl_ff),
      .in_sum     (a_sum_ff),
      .in_bias    (a_bias_ff),
      .relu_on    (relu_ff),
      .bias_on    (bias_on_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // An accepted activation starts a sweep in the next cycle
   assert property (@(posedge clock) disable iff (reset) act_acc |=> issue_ff)
      else $error("activation accepted but no sweep started");

   // A finished sum held by a stalled output stage does not change
   assert property (@(posedge clock) disable iff (reset)
      (a_vld_ff && !post_ready) |=> (a_vld_ff && $stable(a_sum_ff)))
      else $error("finished sum lost during output stall");

   // The last column of a row-ending sweep empties every accumulator
   assert property (@(posedge clock) disable iff (reset)
      acc_clear |=> (acc_vld_ff == '0))
      else $error("accumulators not cleared at row end");

   // No accumulator write-back while a new word is being taken
   assert property (@(posedge clock) disable iff (reset) acc_we |-> !req_tready)
      else $error("accumulator write overlaps an accepted word");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for fused_linear_bias_relu: predicts each row of outputs and compares.
`timescale 1ns / 1ps

module testbench;
   import flbr_pkg::*;

   // Opcode 3 is not a defined word kind; the block drops it
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   localparam int RSP_COL_LSB = RESULT_WIDTH;
   localparam int RSP_ROW_LSB = RESULT_WIDTH + COL_IDX_W;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [RESULT_WIDTH-1:0] value;
      logic [COL_IDX_W-1:0]    col;
      logic [ROW_WIDTH-1:0]    row;
      logic                    row_last;
      logic                    batch_last;
   } out_elem_type;

   // DUT ports
   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [OPCODE_W-1:0]     req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tuser;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   // Predictor state
   logic [ROW_TOTAL_W-1:0]  cfg_rows = 16'd1;
   logic [INNER_LEN_W-1:0]  cfg_inner = 9'd1;
   logic [COL_TOTAL_W-1:0]  cfg_cols = 7'd1;
   logic                    cfg_relu = 1'b0;
   logic                    cfg_bias = 1'b0;
   logic signed [VALUE_W-1:0] weight_mem [MAX_INNER][MAX_COLUMNS];
   bit                      weight_set [MAX_INNER][MAX_COLUMNS];
   logic signed [VALUE_W-1:0] bias_mem [MAX_COLUMNS];
   bit                      bias_set [MAX_COLUMNS];
   logic signed [ACC_WIDTH-1:0] col_acc [MAX_COLUMNS] = '{default: '0};
   int unsigned             inner_pos = 0;
   int unsigned             row_pos = 0;
   out_elem_type            owed_results [$];

   // Run control
   int                      tx_idle_pct = 0;
   int                      rx_idle_pct = 0;
   int                      rx_hold = 0;
   int                      hold_requests = 0;
   int                      hold_seen = 0;
   int                      words_sent = 0;
   int                      mismatches = 0;
   int                      stall_cycles = 0;

   fused_linear_bias_relu i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Effective lengths: zero acts as one, oversize acts as the maximum
   function automatic int unsigned active_columns();
      if (cfg_cols == 0) return 1;
      return (cfg_cols > MAX_COLUMNS) ? MAX_COLUMNS : cfg_cols;
   endfunction

   function automatic int unsigned active_inner();
      if (cfg_inner == 0) return 1;
      return (cfg_inner > MAX_INNER) ? MAX_INNER : cfg_inner;
   endfunction

   function automatic int unsigned active_rows();
      return (cfg_rows == 0) ? 1 : cfg_rows;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_ROW_TOTAL:    cfg_rows = data;
         CSR_INNER_LENGTH: cfg_inner = data[INNER_LEN_W-1:0];
         CSR_COLUMN_TOTAL: cfg_cols = data[COL_TOTAL_W-1:0];
         CSR_RELU_ON:      cfg_relu = data[0];
         CSR_BIAS_ON:      cfg_bias = data[0];
         default: ;
      endcase
   endfunction

   // Predict the effect of one accepted word; a finished row queues its outputs
   function automatic void apply_word(input logic [OPCODE_W-1:0] op,
                                      input logic [INNER_IDX_W-1:0] ii,
                                      input logic [COL_IDX_W-1:0] ci,
                                      input logic [VALUE_W-1:0] val);
      int unsigned cols;
      int unsigned inner;
      int unsigned k;
      bit batch_end;
      logic signed [47:0] v;
      out_elem_type elem;
      case (op)
         OP_WEIGHT: begin
            weight_mem[ii][ci] = val;
            weight_set[ii][ci] = 1'b1;
         end
         OP_BIAS: begin
            bias_mem[ci] = val;
            bias_set[ci] = 1'b1;
         end
         OP_ACT: begin
            cols = active_columns();
            inner = active_inner();
            // a position past a shrunken length counts as the last one
            k = (inner_pos >= inner) ? inner - 1 : inner_pos;
            for (int j = 0; j < cols; j++)
               col_acc[j] = col_acc[j] + $signed(val) * weight_mem[k][j];
            if (k + 1 < inner) begin
               inner_pos = k + 1;
            end else begin
               batch_end = (row_pos + 1 >= active_rows());
               for (int j = 0; j < cols; j++) begin
                  v = col_acc[j];
                  if (cfg_bias) v = v + bias_mem[j] * 256;
                  if (cfg_relu && v < 0) v = 0;
                  if (v > 48'sh0000_7FFF_FFFF) elem.value = 32'h7FFF_FFFF;
                  else if (v < -48'sh0000_8000_0000) elem.value = 32'h8000_0000;
                  else elem.value = v[31:0];
                  elem.col = COL_IDX_W'(j);
                  elem.row = ROW_WIDTH'(row_pos);
                  elem.row_last = (j + 1 == cols);
                  elem.batch_last = (j + 1 == cols) && batch_end;
                  owed_results.push_back(elem);
               end
               col_acc = '{default: '0};
               inner_pos = 0;
               row_pos = batch_end ? 0 : ((row_pos + 1) & 16'hFFFF);
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch @%0t: %s got %0h expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   // Send one word; valid stays high on return so back-to-back words need no gap
   task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [INNER_IDX_W-1:0] ii,
                            input logic [COL_IDX_W-1:0] ci, input logic [VALUE_W-1:0] val);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {{(REQ_DATA_W - REQ_FIELDS_W){1'b0}}, val, ci, ii};
      do @(posedge clock); while (!req_tready);
      apply_word(op, ii, ci, val);
      if (op != OP_UNUSED) words_sent++;
   endtask

   // Write any weight or bias the next activation reads that was never loaded
   task automatic ensure_operands();
      int unsigned cols;
      int unsigned inner;
      int unsigned k;
      cols = active_columns();
      inner = active_inner();
      k = (inner_pos >= inner) ? inner - 1 : inner_pos;
      for (int j = 0; j < cols; j++)
         if (!weight_set[k][j])
            send_word(OP_WEIGHT, INNER_IDX_W'(k), COL_IDX_W'(j), VALUE_W'($urandom));
      if (cfg_bias && k == inner - 1)
         for (int j = 0; j < cols; j++)
            if (!bias_set[j])
               send_word(OP_BIAS, INNER_IDX_W'($urandom), COL_IDX_W'(j), VALUE_W'($urandom));
   endtask

   task automatic send_act(input logic [VALUE_W-1:0] val);
      ensure_operands();
      send_word(OP_ACT, INNER_IDX_W'($urandom), COL_IDX_W'($urandom), val);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_register(idx, data);
      @(posedge clock);
   endtask

   task automatic configure(input int rows, input int inner, input int cols,
                            input bit relu, input bit bias);
      csr_write(CSR_ROW_TOTAL, CSR_DATA_W'(rows));
      csr_write(CSR_INNER_LENGTH, CSR_DATA_W'(inner));
      csr_write(CSR_COLUMN_TOTAL, CSR_DATA_W'(cols));
      csr_write(CSR_RELU_ON, CSR_DATA_W'(relu));
      csr_write(CSR_BIAS_ON, CSR_DATA_W'(bias));
   endtask

   // Stop sending, wait for every owed output, then let a trailing sweep finish
   task automatic drain_and_pause();
      req_tvalid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Extreme weights, biases and activations; ReLU clamps one column; opcode 3 dropped
   task automatic test_store_and_relu();
      configure(2, 2, 2, 1'b1, 1'b1);
      send_word(OP_WEIGHT, 8'd0, 6'd0, 16'h7FFF);
      send_word(OP_WEIGHT, 8'd0, 6'd1, 16'h8000);
      send_word(OP_WEIGHT, 8'd1, 6'd0, 16'h8000);
      send_word(OP_WEIGHT, 8'd1, 6'd1, 16'h0001);
      send_word(OP_BIAS, 8'd0, 6'd0, 16'h8000);
      send_word(OP_BIAS, 8'hFF, 6'd1, 16'h7FFF);
      send_word(OP_WEIGHT, 8'hFF, 6'h3F, 16'h5A5A);
      send_word(OP_UNUSED, 8'hFF, 6'h3F, 16'hFFFF);
      send_act(16'h8000);
      send_act(16'h7FFF);
      send_act(16'h0000);
      send_act(16'hFFFF);
      drain_and_pause();
   endtask

   // Sums beyond the 32-bit range saturate high and low
   task automatic test_saturation();
      configure(2, 4, 1, 1'b0, 1'b0);
      for (int k = 0; k < 4; k++) send_word(OP_WEIGHT, INNER_IDX_W'(k), 6'd0, 16'h8000);
      repeat (4) send_act(16'h8000);
      repeat (4) send_act(16'h7FFF);
      drain_and_pause();
   endtask

   // Weight and bias rewrites in the middle of a row apply at once
   task automatic test_midrow_write();
      configure(1, 2, 1, 1'b0, 1'b1);
      send_word(OP_WEIGHT, 8'd0, 6'd0, 16'h0180);
      send_word(OP_WEIGHT, 8'd1, 6'd0, 16'h0200);
      send_word(OP_BIAS, 8'd0, 6'd0, 16'h0100);
      send_act(16'h0300);
      send_word(OP_WEIGHT, 8'd1, 6'd0, 16'hFE00);
      send_word(OP_BIAS, 8'd0, 6'd0, 16'hFF00);
      send_act(16'h0400);
      drain_and_pause();
   endtask

   // Zero and oversize lengths, then lengths lowered below the current position
   task automatic test_register_extremes();
      configure(0, 511, 0, 1'b0, 1'b0);
      repeat (3) send_act(VALUE_W'($urandom));
      drain_and_pause();
      // inner position 3 now lies past a length of 2: this word ends the row
      csr_write(CSR_INNER_LENGTH, 16'd2);
      send_act(VALUE_W'($urandom));
      drain_and_pause();
      configure(16'hFFFF, 0, 127, 1'b0, 1'b0);
      repeat (2) send_act(VALUE_W'($urandom));
      drain_and_pause();
      // row position past the new total ends the batch
      csr_write(CSR_ROW_TOTAL, 16'd1);
      send_act(VALUE_W'($urandom));
      drain_and_pause();
   endtask

   // Receiver holds off while words keep coming, so the block fills and stalls
   task automatic test_backpressure();
      configure(5, 1, 8, 1'b1, 1'b0);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_requests = hold_requests + 1;
      repeat (5) send_act(VALUE_W'($urandom));
      drain_and_pause();
   endtask

   // Load weights for a random shape, then stream rows with stray writes and noise
   task automatic test_random_traffic(input int tx_pct, input int rx_pct);
      int rows;
      int inner;
      int cols;
      int start;
      int pick;
      logic [VALUE_W-1:0] val;
      drain_and_pause();
      rows = $urandom_range(4, 1);
      inner = $urandom_range(3, 1);
      cols = $urandom_range(4, 1);
      csr_write(CSR_ROW_TOTAL, CSR_DATA_W'(rows));
      csr_write(CSR_INNER_LENGTH, {7'($urandom), 9'(inner)});
      csr_write(CSR_COLUMN_TOTAL, {9'($urandom), 7'(cols)});
      csr_write(CSR_RELU_ON, CSR_DATA_W'($urandom));
      csr_write(CSR_BIAS_ON, CSR_DATA_W'($urandom));
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int k = 0; k < inner; k++)
         for (int j = 0; j < cols; j++)
            send_word(OP_WEIGHT, INNER_IDX_W'(k), COL_IDX_W'(j), VALUE_W'($urandom));
      for (int j = 0; j < cols; j++)
         send_word(OP_BIAS, INNER_IDX_W'($urandom), COL_IDX_W'(j), VALUE_W'($urandom));
      start = words_sent;
      while (words_sent - start < 6 || inner_pos != 0) begin
         pick = $urandom_range(99);
         if (pick < 8)
            send_word(OP_UNUSED, INNER_IDX_W'($urandom), COL_IDX_W'($urandom),
                      VALUE_W'($urandom));
         else if (pick < 16)
            send_word(OP_WEIGHT, INNER_IDX_W'($urandom), COL_IDX_W'($urandom),
                      VALUE_W'($urandom));
         else if (pick < 20)
            send_word(OP_BIAS, INNER_IDX_W'($urandom), COL_IDX_W'($urandom),
                      VALUE_W'($urandom));
         if ($urandom_range(9) == 0)
            val = $urandom_range(1) ? 16'h7FFF : 16'h8000;
         else
            val = VALUE_W'($urandom);
         send_act(val);
      end
      drain_and_pause();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
   endtask

   // Receiver readiness: random idling, or a counted hold-off
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         rx_hold <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold <= rx_hold - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Compare each output word with the oldest owed result
   always @(posedge clock) begin : check_outputs
      out_elem_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_results.size() == 0) begin
            report_mismatch("output word with none owed", 64'(rsp_tdata), 64'd0);
         end else begin
            want = owed_results.pop_front();
            if (rsp_tdata[RESULT_WIDTH-1:0] !== want.value)
               report_mismatch("result_value", 64'(rsp_tdata[RESULT_WIDTH-1:0]),
                               64'(want.value));
            if (rsp_tdata[RSP_COL_LSB +: COL_IDX_W] !== want.col)
               report_mismatch("result_column", 64'(rsp_tdata[RSP_COL_LSB +: COL_IDX_W]),
                               64'(want.col));
            if (rsp_tdata[RSP_ROW_LSB +: ROW_WIDTH] !== want.row)
               report_mismatch("result_row", 64'(rsp_tdata[RSP_ROW_LSB +: ROW_WIDTH]),
                               64'(want.row));
            if (rsp_tlast !== want.row_last)
               report_mismatch("row_last", 64'(rsp_tlast), 64'(want.row_last));
            if (rsp_tuser !== want.batch_last)
               report_mismatch("batch_last", 64'(rsp_tuser), 64'(want.batch_last));
         end
      end
   end

   // Watchdog: too long without any word moving on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_store_and_relu();
      test_saturation();
      test_midrow_write();
      test_register_extremes();
      test_backpressure();
      test_random_traffic(15, 88);
      test_random_traffic(88, 15);
      test_random_traffic(0, 0);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/flbr_pkg.sv
rtl/core/flbr_post.sv
rtl/core/fused_linear_bias_relu.sv
tb/sv/testbench.sv
